// ----- src/aabd_pkg.sv -----
package aabd_pkg;

  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // magnitudes from here on scale above 9999
  localparam logic [15:0] MAG_SAT    = 16'd2565;
  // ceil(2^24 / 10) * 39
  localparam logic [25:0] SCALE_MUL  = 26'd65431158;
  localparam logic [13:0] MAG_LIMIT  = 14'd9999;

  localparam logic [14:0] RECIP_1000 = 15'd16778;
  localparam logic [9:0]  RECIP_100  = 10'd656;
  localparam logic [6:0]  RECIP_10   = 7'd103;

  localparam logic [13:0] THOUSAND   = 14'd1000;
  localparam logic [9:0]  HUNDRED    = 10'd100;
  localparam logic [6:0]  TEN        = 7'd10;

  typedef struct packed {
    axis_t       axis;
    logic        neg;
    logic [15:0] mag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- src/accel_axis_to_bcd_display.sv -----
// channel  | direction | tdata (lowest bit up)                          | tuser
// in_      | slave     | button_level, x_byte_low, x_byte_high,         | -
//          |           | y_byte_low, y_byte_high, z_byte_low,           |
//          |           | z_byte_high, 7 zero bits                       |
// out_     | master    | digit_ones, digit_tens, digit_hundreds,        | shown_axis
//          |           | digit_thousands, minus_sign, 7 zero bits       |
//
// One transaction per cycle in and out while nothing stalls; the scaling
// multiply and the three digit stages of the back pipeline are registered.
// out_tvalid rises once an accepted entry has passed the queue and stages.
// A two-entry queue parts the front from the back pipeline; out_tready low
// holds the pipeline and in_tready falls once the queue fills.
// Reset: axis X, button released, queue and pipeline empty.
module accel_axis_to_bcd_display (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // button_level[0], x_byte_low[8:1], x_byte_high[16:9], y_byte_low[24:17],
  // y_byte_high[32:25], z_byte_low[40:33], z_byte_high[48:41], zero[55:49]
  input  logic [aabd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // digit_ones[3:0], digit_tens[7:4], digit_hundreds[11:8],
  // digit_thousands[15:12], minus_sign[16], zero[23:17]
  output logic [aabd_pkg::OUT_DATA_W-1:0] out_tdata,
  // shown_axis[1:0]
  output logic [aabd_pkg::OUT_USER_W-1:0] out_tuser
);

  logic                push;
  logic                pop;
  aabd_pkg::entry_t    push_data;
  aabd_pkg::entry_t    pop_data;
  aabd_pkg::q_status_t q_status;

  aabd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  aabd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  aabd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- src/aabd_front.sv -----
module aabd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [aabd_pkg::IN_DATA_W-1:0] in_tdata,
  input  aabd_pkg::q_status_t            q_status,
  output logic                           push,
  output aabd_pkg::entry_t               push_data
);

  logic            last_button_r;
  logic            last_button_nxt;
  aabd_pkg::axis_t axis_r;
  aabd_pkg::axis_t axis_nxt;
  logic            button;
  logic [15:0]     word;
  logic            accept;

  assign button    = in_tdata[0];
  assign in_tready = ~q_status.full;
  assign accept    = in_tvalid & in_tready;
  assign push      = accept;

  always_comb begin
    axis_nxt        = axis_r;
    last_button_nxt = button;
    if (last_button_r && !button) begin
      if (axis_r >= aabd_pkg::AXIS_Z) begin
        axis_nxt = aabd_pkg::AXIS_X;
      end else begin
        axis_nxt = axis_r + 2'd1;
      end
    end
  end

  always_comb begin
    case (axis_nxt)
      aabd_pkg::AXIS_X: word = in_tdata[16:1];
      aabd_pkg::AXIS_Y: word = in_tdata[32:17];
      default:          word = in_tdata[48:33];
    endcase
    push_data.axis = axis_nxt;
    push_data.neg  = word[15];
    push_data.mag  = word[15] ? (~word + 16'd1) : word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_button_r <= 1'b1;
      axis_r        <= aabd_pkg::AXIS_X;
    end else if (accept) begin
      last_button_r <= last_button_nxt;
      axis_r        <= axis_nxt;
    end
  end

endmodule

// ----- src/aabd_queue.sv -----
module aabd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aabd_pkg::entry_t    push_data,
  input  logic                pop,
  output aabd_pkg::entry_t    pop_data,
  output aabd_pkg::q_status_t status
);

  aabd_pkg::entry_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/aabd_back.sv -----
module aabd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  aabd_pkg::q_status_t             q_status,
  input  aabd_pkg::entry_t                q_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [aabd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [aabd_pkg::OUT_USER_W-1:0] out_tuser
);

  logic            v1_r, v2_r, v3_r, v4_r;
  logic            rdy1, rdy2, rdy3, rdy4;
  aabd_pkg::axis_t axis1_r, axis2_r, axis3_r, axis4_r;
  logic            neg1_r, neg2_r, neg3_r, neg4_r;
  logic [13:0]     val1_r;
  logic [3:0]      thou2_r, thou3_r, thou4_r;
  logic [9:0]      rem2_r;
  logic [3:0]      hund3_r, hund4_r;
  logic [6:0]      rem3_r;
  logic [3:0]      tens4_r, ones4_r;

  logic [37:0]     prod1;
  logic [13:0]     val1_nxt;
  logic [28:0]     prod2;
  logic [3:0]      thou2_nxt;
  logic [9:0]      rem2_nxt;
  logic [19:0]     prod3;
  logic [3:0]      hund3_nxt;
  logic [6:0]      rem3_nxt;
  logic [13:0]     prod4;
  logic [3:0]      tens4_nxt;
  logic [3:0]      ones4_nxt;

  assign rdy4 = ~v4_r | out_tready;
  assign rdy3 = ~v3_r | rdy4;
  assign rdy2 = ~v2_r | rdy3;
  assign rdy1 = ~v1_r | rdy2;
  assign pop  = rdy1 & ~q_status.empty;

  always_comb begin
    prod1    = 38'(q_data.mag[11:0]) * 38'(aabd_pkg::SCALE_MUL);
    val1_nxt = (q_data.mag >= aabd_pkg::MAG_SAT) ? aabd_pkg::MAG_LIMIT : prod1[37:24];

    prod2     = 29'(val1_r) * 29'(aabd_pkg::RECIP_1000);
    thou2_nxt = prod2[27:24];
    rem2_nxt  = 10'(val1_r - 14'(14'(thou2_nxt) * aabd_pkg::THOUSAND));

    prod3     = 20'(rem2_r) * 20'(aabd_pkg::RECIP_100);
    hund3_nxt = prod3[19:16];
    rem3_nxt  = 7'(rem2_r - 10'(10'(hund3_nxt) * aabd_pkg::HUNDRED));

    prod4     = 14'(rem3_r) * 14'(aabd_pkg::RECIP_10);
    tens4_nxt = prod4[13:10];
    ones4_nxt = 4'(rem3_r - 7'(7'(tens4_nxt) * aabd_pkg::TEN));
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      axis1_r <= q_data.axis;
      neg1_r  <= q_data.neg;
      val1_r  <= val1_nxt;
    end
    if (rdy2) begin
      axis2_r <= axis1_r;
      neg2_r  <= neg1_r;
      thou2_r <= thou2_nxt;
      rem2_r  <= rem2_nxt;
    end
    if (rdy3) begin
      axis3_r <= axis2_r;
      neg3_r  <= neg2_r;
      thou3_r <= thou2_r;
      hund3_r <= hund3_nxt;
      rem3_r  <= rem3_nxt;
    end
    if (rdy4) begin
      axis4_r <= axis3_r;
      neg4_r  <= neg3_r;
      thou4_r <= thou3_r;
      hund4_r <= hund3_r;
      tens4_r <= tens4_nxt;
      ones4_r <= ones4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= pop;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = axis4_r;
  assign out_tdata  = {7'd0, neg4_r, thou4_r, hund4_r, tens4_r, ones4_r};

endmodule

// ----- src/aabd_checker.sv -----
module aabd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [aabd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [aabd_pkg::OUT_USER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out_ transaction changed while stalled");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("shown axis out of range");

  a_digits_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd9 && out_tdata[7:4] <= 4'd9 &&
                   out_tdata[11:8] <= 4'd9 && out_tdata[15:12] <= 4'd9 &&
                   out_tdata[23:17] == 7'd0)
    else $error("digit not decimal or padding set");

  a_zero_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] == 16'd0 |-> !out_tdata[16])
    else $error("zero shown with minus sign");

endmodule

bind accel_axis_to_bcd_display aabd_checker u_aabd_checker (.*);

// ----- tb/tb_accel_axis_to_bcd_display.sv -----
`timescale 1ns / 1ps

module tb_accel_axis_to_bcd_display;

  localparam int unsigned MG_NUM         = 39;
  localparam int unsigned MG_DEN         = 10;
  localparam int unsigned MILLI_G_CAP    = 9999;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          RANDOM_PER_RUN = 130;

  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] z_hi;
    logic [7:0] z_lo;
    logic [7:0] y_hi;
    logic [7:0] y_lo;
    logic [7:0] x_hi;
    logic [7:0] x_lo;
    logic       btn;
  } sample_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       minus;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  typedef struct packed {
    aabd_pkg::axis_t axis;
    digits_t         digits;
  } display_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [aabd_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [aabd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [aabd_pkg::OUT_USER_W-1:0] out_tuser;

  sample_t  sample_q[$];
  display_t display_q[$];

  logic            btn_prev      = 1'b1;
  aabd_pkg::axis_t axis_sel      = aabd_pkg::AXIS_X;
  logic            in_taken      = 1'b0;
  int              send_idle_pct = 34;
  int              recv_idle_pct = 61;
  int              queued_cnt    = 0;
  int              accepted_cnt  = 0;
  int              idle_cycles   = 0;
  int              err_count     = 0;

  accel_axis_to_bcd_display DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the axis on a press, then scale and split the selected word
  function automatic display_t predict_display(sample_t s);
    logic [15:0] word;
    logic [16:0] mag;
    int unsigned milli_g;
    display_t    d;
    if (btn_prev && !s.btn) begin
      axis_sel = (axis_sel >= aabd_pkg::AXIS_Z) ? aabd_pkg::AXIS_X :
                 aabd_pkg::axis_t'(axis_sel + 2'd1);
    end
    btn_prev = s.btn;
    case (axis_sel)
      aabd_pkg::AXIS_X: word = {s.x_hi, s.x_lo};
      aabd_pkg::AXIS_Y: word = {s.y_hi, s.y_lo};
      default:          word = {s.z_hi, s.z_lo};
    endcase
    mag = word[15] ? 17'h10000 - {1'b0, word} : {1'b0, word};
    milli_g = (32'(mag) * MG_NUM) / MG_DEN;
    if (milli_g > MILLI_G_CAP) begin
      milli_g = MILLI_G_CAP;
    end
    d = '0;
    d.axis             = axis_sel;
    d.digits.ones      = 4'(milli_g % 10);
    d.digits.tens      = 4'((milli_g / 10) % 10);
    d.digits.hundreds  = 4'((milli_g / 100) % 10);
    d.digits.thousands = 4'((milli_g / 1000) % 10);
    d.digits.minus     = word[15];
    return d;
  endfunction

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    case ($urandom_range(4, 0))
      0: w = 16'($urandom_range(2570, 2558));
      1: w = 16'($urandom_range(20, 0));
      2: begin
        case ($urandom_range(3, 0))
          0:       w = 16'h0000;
          1:       w = 16'h7FFF;
          2:       w = 16'h8000;
          default: w = 16'hFFFF;
        endcase
      end
      default: return 16'($urandom());
    endcase
    return $urandom_range(1, 0) ? -w : w;
  endfunction

  task automatic push_words(logic btn, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_t s;
    s = '0;
    s.btn  = btn;
    s.x_lo = x[7:0];
    s.x_hi = x[15:8];
    s.y_lo = y[7:0];
    s.y_hi = y[15:8];
    s.z_lo = z[7:0];
    s.z_hi = z[15:8];
    sample_q.push_back(s);
    queued_cnt++;
  endtask

  task automatic push_random(int count);
    repeat (count) begin
      push_words($urandom_range(3, 0) != 0, rand_word(), rand_word(), rand_word());
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (accepted_cnt != queued_cnt || display_q.size() != 0);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // hold tvalid until the transaction is taken
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tdata  <= sample_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sample_t  s;
    display_t want;
    digits_t  got;
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (display_q.size() == 0) begin
          $error("unexpected result: tdata %h tuser %0d", out_tdata, out_tuser);
          err_count++;
        end else begin
          want = display_q.pop_front();
          compare_field("shown_axis", want.axis, out_tuser);
          compare_field("digit_ones", want.digits.ones, got.ones);
          compare_field("digit_tens", want.digits.tens, got.tens);
          compare_field("digit_hundreds", want.digits.hundreds, got.hundreds);
          compare_field("digit_thousands", want.digits.thousands, got.thousands);
          compare_field("minus_sign", want.digits.minus, got.minus);
        end
      end
      if (in_tvalid && in_tready) begin
        s = in_tdata;
        display_q.push_back(predict_display(s));
        accepted_cnt++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[accel_axis_to_bcd_display] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_words(1'b1, 16'h0000, 16'h1234, 16'h8000);
    push_words(1'b1, 16'h7FFF, 16'h0000, 16'h0000);
    push_words(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);
    push_words(1'b1, 16'hFFFF, 16'h0001, 16'h0001);
    push_words(1'b1, 16'd2564, 16'h8000, 16'h7FFF);
    push_words(1'b1, 16'd2565, 16'hFFFF, 16'h0000);
    push_words(1'b1, -16'd2564, 16'h0000, 16'h0000);
    push_words(1'b1, -16'd2565, 16'h0000, 16'h0000);
    push_words(1'b0, 16'h7FFF, 16'h8000, 16'h0001);
    push_words(1'b0, 16'h8000, 16'h0001, 16'hFFFF);
    push_words(1'b1, 16'h0000, 16'h7FFF, 16'h8000);
    push_words(1'b0, 16'h0001, 16'h8001, 16'hFFFF);
    push_words(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_words(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000);
    push_words(1'b1, 16'h0001, 16'h0000, 16'h0000);
    push_words(1'b1, 16'h00FF, 16'hFF00, 16'h5555);
    push_words(1'b1, 16'hFF00, 16'hAAAA, 16'h00FF);
    push_random(RANDOM_PER_RUN);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 34;
    push_random(RANDOM_PER_RUN);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(RANDOM_PER_RUN);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("[accel_axis_to_bcd_display] OK");
    end else begin
      $display("[accel_axis_to_bcd_display] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/aabd_pkg.sv
src/aabd_front.sv
src/aabd_queue.sv
src/aabd_back.sv
src/accel_axis_to_bcd_display.sv
src/aabd_checker.sv
tb/tb_accel_axis_to_bcd_display.sv
